// ----- rtl/sphere_aabb_contact_unit_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef SPHERE_AABB_CONTACT_UNIT_MACROS_SVH
`define SPHERE_AABB_CONTACT_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define SAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication in the following cycle, outside reset.
`define SAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sac_pkg.sv -----
`default_nettype none
package sac_pkg;
    localparam int CoordW  = 32;
    localparam int HalfW   = CoordW - 1;
    localparam int ExtW    = CoordW + 2;
    localparam int DiffW   = CoordW + 2;
    localparam int MagW    = CoordW + 1;
    localparam int SqW     = 2 * MagW + 2;
    localparam int RootW   = SqW / 2;
    localparam int TagW    = 16;
    localparam int NormW   = 18;
    localparam int NormF   = 16;
    localparam int QDepth  = 4;
    localparam int QPtrW   = 2;
    localparam int RootLat = RootW;
    localparam int DivLat  = NormF + 1;

    // Classified item passed from the front part to the back part
    typedef struct packed {
        logic                   hit;
        logic [TagW-1:0]        tag;
        logic signed [ExtW-1:0] cl_x;
        logic signed [ExtW-1:0] cl_y;
        logic signed [ExtW-1:0] cl_z;
        logic [MagW-1:0]        m_x;
        logic [MagW-1:0]        m_y;
        logic [MagW-1:0]        m_z;
        logic [2:0]             pos;      // offset strictly positive per axis
        logic [SqW-1:0]         d2;
        logic [1:0]             face_ax;
        logic                   face_neg; // face normal is minus one
        logic [HalfW-1:0]       radius;
    } t_item;
endpackage
`default_nettype wire

// ----- rtl/sac_front.sv -----
`default_nettype none
// Clamp, squared distance and face choice; three registered stages
module sac_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [sac_pkg::TagW-1:0]   i_tag,
    input  wire logic [sac_pkg::CoordW-1:0] i_sx, i_sy, i_sz,
    input  wire logic [sac_pkg::HalfW-1:0]  i_r,
    input  wire logic [sac_pkg::CoordW-1:0] i_bx, i_by, i_bz,
    input  wire logic [sac_pkg::HalfW-1:0]  i_hx, i_hy, i_hz,
    output logic               o_vld,
    output sac_pkg::t_item     o_item
);
    localparam int EW = sac_pkg::ExtW;
    localparam int MW = sac_pkg::MagW;
    localparam int SW = sac_pkg::SqW;

    logic [2:0] r_vld;
    // stage 1 results
    logic signed [EW-1:0] r_cl [3];
    logic [MW-1:0]        r_m [3];
    logic [2:0]           r_pos;
    logic signed [EW-1:0] r_fd [3];
    logic [2:0]           r_dlneg;
    logic [sac_pkg::TagW-1:0]  r_tag1, r_tag2, r_tag3;
    logic [sac_pkg::HalfW-1:0] r_r1, r_r2, r_r3;
    // stage 2 and stage 3 results
    logic [2*MW-1:0]      r_sq [3];
    logic [2*MW-3:0]      r_r2sq;
    logic signed [EW-1:0] r_cl2 [3], r_cl3 [3];
    logic [MW-1:0]        r_m2 [3], r_m3 [3];
    logic [2:0]           r_pos2, r_pos3;
    logic [1:0]           r_ax2, r_ax3;
    logic                 r_neg2, r_neg3;
    logic [SW-1:0]        r_d2;
    logic                 r_hit;

    logic signed [EW-1:0] s [3], bc [3], lo [3], hi [3], cl [3], dd [3], dl [3];
    logic [EW-1:0]        hf [3];
    logic [MW-1:0]        adl [3];
    logic [1:0]           ax;
    logic [SW-1:0]        d2sum;

    // clamp the sphere centre into the box per axis
    always_comb begin
        s[0]  = EW'($signed(i_sx)); s[1]  = EW'($signed(i_sy)); s[2]  = EW'($signed(i_sz));
        bc[0] = EW'($signed(i_bx)); bc[1] = EW'($signed(i_by)); bc[2] = EW'($signed(i_bz));
        hf[0] = EW'(i_hx); hf[1] = EW'(i_hy); hf[2] = EW'(i_hz);
        for (int k = 0; k < 3; k++) begin
            lo[k]  = bc[k] - $signed(hf[k]);
            hi[k]  = bc[k] + $signed(hf[k]);
            cl[k]  = (s[k] < lo[k]) ? lo[k] : ((s[k] > hi[k]) ? hi[k] : s[k]);
            dd[k]  = s[k] - cl[k];
            dl[k]  = s[k] - bc[k];
            adl[k] = dl[k][EW-1] ? MW'(-dl[k]) : MW'(dl[k]);
        end
    end

    // pick the nearest face, lower axis on ties; sum the squared offsets
    always_comb begin
        ax = 2'd0;
        if (r_fd[1] < r_fd[0]) ax = 2'd1;
        if (r_fd[2] < ((ax == 2'd1) ? r_fd[1] : r_fd[0])) ax = 2'd2;
        d2sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // advance the payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_cl[k] <= cl[k];
                r_m[k]  <= dd[k][EW-1] ? MW'(-dd[k]) : MW'(dd[k]);
                r_pos[k] <= !dd[k][EW-1] && (dd[k] != '0);
                r_fd[k] <= $signed(hf[k]) - $signed(EW'(adl[k]));
                r_dlneg[k] <= dl[k][EW-1];
                r_sq[k]  <= (2*MW)'(r_m[k]) * (2*MW)'(r_m[k]);
                r_cl2[k] <= r_cl[k];
                r_m2[k]  <= r_m[k];
                r_cl3[k] <= r_cl2[k];
                r_m3[k]  <= r_m2[k];
            end
            r_tag1 <= i_tag; r_r1 <= i_r;
            r_tag2 <= r_tag1; r_r2 <= r_r1;
            r_tag3 <= r_tag2; r_r3 <= r_r2;
            r_r2sq <= (2*MW-2)'(r_r1) * (2*MW-2)'(r_r1);
            r_pos2 <= r_pos; r_pos3 <= r_pos2;
            r_ax2  <= ax;    r_ax3 <= r_ax2;
            r_neg2 <= !r_dlneg[ax]; r_neg3 <= r_neg2;
            r_d2   <= d2sum;
            r_hit  <= d2sum <= SW'(r_r2sq);
        end
    end

    always_comb begin
        o_vld           = r_vld[2];
        o_item.hit      = r_hit;
        o_item.tag      = r_tag3;
        o_item.cl_x     = r_cl3[0];
        o_item.cl_y     = r_cl3[1];
        o_item.cl_z     = r_cl3[2];
        o_item.m_x      = r_m3[0];
        o_item.m_y      = r_m3[1];
        o_item.m_z      = r_m3[2];
        o_item.pos      = r_pos3;
        o_item.d2       = r_d2;
        o_item.face_ax  = r_ax3;
        o_item.face_neg = r_neg3;
        o_item.radius   = r_r3;
    end
endmodule
`default_nettype wire

// ----- rtl/sac_queue.sv -----
`default_nettype none
// Short queue between the two parts, registers only
module sac_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  sac_pkg::t_item      i_item,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [sac_pkg::QPtrW:0] o_count,
    output sac_pkg::t_item      o_item
);
    sac_pkg::t_item r_mem [sac_pkg::QDepth];
    logic [sac_pkg::QPtrW-1:0] r_wp, r_rp;
    logic [sac_pkg::QPtrW:0]   r_cnt;
    logic                      do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (sac_pkg::QPtrW+1)'(i_push) - (sac_pkg::QPtrW+1)'(do_pop);
        end
    end

    // store the incoming item
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

// ----- rtl/sac_back.sv -----
`default_nettype none
// Pipelined root, then three pipelined restoring dividers
module sac_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  sac_pkg::t_item   i_item,
    output logic             o_vld,
    output logic             o_hit,
    output logic [sac_pkg::TagW-1:0] o_tag,
    output logic [sac_pkg::CoordW:0] o_cx, o_cy, o_cz,
    output logic [sac_pkg::NormW-1:0] o_nx, o_ny, o_nz,
    output logic [sac_pkg::HalfW-1:0] o_pen
);
    localparam int RW = sac_pkg::RootW;
    localparam int SW = sac_pkg::SqW;
    localparam int RL = sac_pkg::RootLat;
    localparam int DL = sac_pkg::DivLat;
    localparam int MW = sac_pkg::MagW;
    localparam int NW = sac_pkg::NormW;
    localparam int AW = MW + 1;
    localparam int NormQW = sac_pkg::NormF + 1;

    // root stages: one result bit per stage
    logic [RL:0]       r_rv;
    sac_pkg::t_item    r_ri [RL+1];
    logic [RW-1:0]     r_res [RL+1];
    logic [SW-1:0]     r_rem [RL+1];
    // divide stages
    logic [DL:0]       r_dv;
    sac_pkg::t_item    r_di [DL+1];
    logic [RW-1:0]     r_den [DL+1];
    logic [AW-1:0]     r_a [DL+1][3];
    logic [NormQW-1:0] r_q [DL+1][3];

    logic [RW-1:0] res_n [RL];
    logic [SW-1:0] rem_n [RL];
    logic [AW-1:0] a_n [DL][3];
    logic [NormQW-1:0] q_n [DL][3];

    // square root: restoring, two radicand bits in and one result bit out per stage
    always_comb begin
        for (int k = 0; k < RL; k++) begin
            logic [SW-1:0] rs;
            logic [SW-1:0] trial;
            rs    = {r_rem[k][SW-3:0], r_ri[k].d2[2*(RL-1-k) +: 2]};
            trial = SW'({r_res[k], 2'b01});
            if (rs >= trial) begin
                rem_n[k] = rs - trial;
                res_n[k] = {r_res[k][RW-2:0], 1'b1};
            end else begin
                rem_n[k] = rs;
                res_n[k] = {r_res[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0; r_dv <= '0;
        end else if (i_en) begin
            r_rv <= {r_rv[RL-1:0], i_vld};
            r_dv <= {r_dv[DL-1:0], r_rv[RL]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ri[0] <= i_item; r_res[0] <= '0; r_rem[0] <= '0;
            for (int k = 0; k < RL; k++) begin
                r_ri[k+1] <= r_ri[k]; r_res[k+1] <= res_n[k]; r_rem[k+1] <= rem_n[k];
            end
            r_di[0]  <= r_ri[RL];
            r_den[0] <= r_res[RL];
            r_a[0][0] <= AW'(r_ri[RL].m_x);
            r_a[0][1] <= AW'(r_ri[RL].m_y);
            r_a[0][2] <= AW'(r_ri[RL].m_z);
            for (int j = 0; j < 3; j++) r_q[0][j] <= '0;
            for (int k = 0; k < DL; k++) begin
                r_di[k+1] <= r_di[k]; r_den[k+1] <= r_den[k];
                for (int j = 0; j < 3; j++) begin
                    r_a[k+1][j] <= a_n[k][j]; r_q[k+1][j] <= q_n[k][j];
                end
            end
        end
    end

    // restoring divide: first step gives the integer bit, then one fraction bit each
    always_comb begin
        for (int k = 0; k < DL; k++) begin
            for (int j = 0; j < 3; j++) begin
                logic [AW-1:0] sh;
                sh = (k == 0) ? r_a[k][j] : {r_a[k][j][AW-2:0], 1'b0};
                if (sh >= AW'(r_den[k])) begin
                    a_n[k][j] = sh - AW'(r_den[k]);
                    q_n[k][j] = {r_q[k][j][NormQW-2:0], 1'b1};
                end else begin
                    a_n[k][j] = sh;
                    q_n[k][j] = {r_q[k][j][NormQW-2:0], 1'b0};
                end
            end
        end
    end

    // assemble the result
    always_comb begin
        sac_pkg::t_item it;
        logic [NW-1:0] n [3];
        logic [NW-1:0] one;
        it  = r_di[DL];
        one = NW'(1) << sac_pkg::NormF;
        for (int j = 0; j < 3; j++) begin
            if (r_den[DL] != '0)
                n[j] = it.pos[j] ? NW'(-NW'(r_q[DL][j])) : NW'(r_q[DL][j]);
            else if (it.face_ax == 2'(j))
                n[j] = it.face_neg ? NW'(-one) : one;
            else
                n[j] = '0;
        end
        o_vld = r_dv[DL];
        o_hit = it.hit;
        o_tag = it.hit ? it.tag : '0;
        o_cx  = it.hit ? it.cl_x[sac_pkg::CoordW:0] : '0;
        o_cy  = it.hit ? it.cl_y[sac_pkg::CoordW:0] : '0;
        o_cz  = it.hit ? it.cl_z[sac_pkg::CoordW:0] : '0;
        o_nx  = it.hit ? n[0] : '0;
        o_ny  = it.hit ? n[1] : '0;
        o_nz  = it.hit ? n[2] : '0;
        o_pen = it.hit ? it.radius - r_den[DL][sac_pkg::HalfW-1:0] : '0;
    end
endmodule
`default_nettype wire

// ----- rtl/sphere_aabb_contact_unit.sv -----
`default_nettype none
// Sphere versus axis-aligned box contact test in signed Q16.16. One request is accepted per
// cycle while full is low; its result is registered in order through three front stages
// that clamp, square and pick the nearest face, the middle queue, the root with an input
// stage and 34 stages of one bit each, the dividers with an input stage and 17 stages of one
// quotient bit each, and the output queue, from which it can be popped.
// Results leave in request order. The middle and output queues hold four entries each. When
// the result side stops popping, the back part stalls once its last stage holds a result that
// the output queue cannot take, then the front part stalls the same way on the middle queue,
// and full is high exactly while the front part is stalled. A miss returns hit low with every
// other field zero.
module sphere_aabb_contact_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        pop,
    output logic             empty,
    input  wire logic [15:0] i_pair_tag,
    input  wire logic [31:0] i_sphere_x, i_sphere_y, i_sphere_z,
    input  wire logic [30:0] i_radius,
    input  wire logic [31:0] i_box_x, i_box_y, i_box_z,
    input  wire logic [30:0] i_half_x, i_half_y, i_half_z,
    output logic             o_hit,
    output logic [15:0]      o_tag_out,
    output logic [32:0]      o_contact_x, o_contact_y, o_contact_z,
    output logic [17:0]      o_normal_x, o_normal_y, o_normal_z,
    output logic [30:0]      o_penetration
);
    localparam int QW = 1 + 16 + 3*33 + 3*18 + 31;
    localparam int CW = sac_pkg::QPtrW + 1;

    sac_pkg::t_item f_item, q_item;
    logic f_vld, q_empty, b_vld;
    logic en_f, en_b, f_push, q_pop, b_wr;
    logic [sac_pkg::QPtrW:0] q_cnt;
    logic [QW-1:0] r_oq [sac_pkg::QDepth];
    logic [sac_pkg::QPtrW:0] r_ocnt;
    logic [sac_pkg::QPtrW-1:0] r_wp, r_rp;
    logic acc, deq;
    logic [QW-1:0] b_word;
    logic b_hit; logic [15:0] b_tag; logic [32:0] b_cx, b_cy, b_cz;
    logic [17:0] b_nx, b_ny, b_nz; logic [30:0] b_pen;

    // stall the back part while its last stage holds a result and the output queue is full
    assign en_b   = !(b_vld && (r_ocnt == CW'(sac_pkg::QDepth)));
    assign b_wr   = b_vld && en_b;
    assign q_pop  = en_b && !q_empty;
    // stall the front part while its last stage holds a request and the middle queue is full
    assign en_f   = !(f_vld && (q_cnt == CW'(sac_pkg::QDepth)));
    assign f_push = f_vld && en_f;
    assign full   = !en_f;
    assign acc    = push && !full;
    assign deq    = pop && !empty;

    sac_front u_front (
        .i_clk, .i_rst_n, .i_en(en_f), .i_vld(acc), .i_tag(i_pair_tag),
        .i_sx(i_sphere_x), .i_sy(i_sphere_y), .i_sz(i_sphere_z), .i_r(i_radius),
        .i_bx(i_box_x), .i_by(i_box_y), .i_bz(i_box_z),
        .i_hx(i_half_x), .i_hy(i_half_y), .i_hz(i_half_z),
        .o_vld(f_vld), .o_item(f_item)
    );

    sac_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_push), .i_item(f_item), .i_pop(q_pop),
        .o_empty(q_empty), .o_count(q_cnt), .o_item(q_item)
    );

    sac_back u_back (
        .i_clk, .i_rst_n, .i_en(en_b), .i_vld(!q_empty), .i_item(q_item),
        .o_vld(b_vld), .o_hit(b_hit), .o_tag(b_tag), .o_cx(b_cx), .o_cy(b_cy), .o_cz(b_cz),
        .o_nx(b_nx), .o_ny(b_ny), .o_nz(b_nz), .o_pen(b_pen)
    );

    assign b_word = {b_hit, b_tag, b_cx, b_cy, b_cz, b_nx, b_ny, b_nz, b_pen};
    assign empty  = (r_ocnt == '0);
    assign {o_hit, o_tag_out, o_contact_x, o_contact_y, o_contact_z,
            o_normal_x, o_normal_y, o_normal_z, o_penetration} = r_oq[r_rp];

    // track results waiting in the output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0; r_wp <= '0; r_rp <= '0;
        end else begin
            r_ocnt <= r_ocnt + CW'(b_wr) - CW'(deq);
            if (b_wr) r_wp <= r_wp + 1'b1;
            if (deq)  r_rp <= r_rp + 1'b1;
        end
    end

    // hold finished results
    always_ff @(posedge i_clk) begin
        if (b_wr) r_oq[r_wp] <= b_word;
    end
endmodule
`default_nettype wire

// ----- rtl/sac_checker.sv -----
`default_nettype none
`include "sphere_aabb_contact_unit_macros.svh"
// Port-level checks for the contact unit
module sac_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic        o_hit,
    input wire logic [15:0] o_tag_out,
    input wire logic [17:0] o_normal_x,
    input wire logic [30:0] o_penetration
);
    `SAC_ASSERT_IMP(a_miss_tag, i_clk, i_rst_n, !empty && !o_hit, o_tag_out == '0)
    `SAC_ASSERT_IMP(a_miss_pen, i_clk, i_rst_n, !empty && !o_hit, o_penetration == '0)
    `SAC_ASSERT_IMP(a_norm_range, i_clk, i_rst_n, !empty, $signed(o_normal_x) <= 18'sd65536 && $signed(o_normal_x) >= -18'sd65536)
    `SAC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty)
endmodule

bind sphere_aabb_contact_unit sac_checker u_sac_checker (
    .i_clk, .i_rst_n, .pop, .empty,
    .o_hit, .o_tag_out, .o_normal_x, .o_penetration
);
`default_nettype wire
